>>> rtl/bbd_pkg.sv
package bbd_pkg;

    // Register field widths
    localparam int FW_W = 11;
    localparam int FH_W = 13;

    // Register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd324;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd244;

    // Register index, taken from paddr[3:2]
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRAY_MODE    = 2'd2;

    // Input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Divide by three as (s * 683) >> 11, exact for s below 2048
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PROD_W = 20;

    typedef logic [7:0] pix_t;

    // What stage one needs to know about an item
    typedef struct packed {
        logic raw;      // pixel item: shift the window and write the line stores
        logic emit;     // item produces a result
        logic border;   // result position lies on the frame border
        logic last;     // result position is the last one of the frame
        logic x_odd;
        logic y_odd;
        logic gray;     // gray mode at acceptance
    } tag_t;

endpackage

>>> rtl/bbd_ram.sv
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bbd_ctrl.sv
module bbd_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          cmd,
    input  logic [bbd_pkg::FW_W-1:0]      frame_width,
    input  logic [bbd_pkg::FH_W-1:0]      frame_height,
    input  logic                          gray_mode,
    output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output bbd_pkg::tag_t                 tag
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PW    = $clog2(MAX_WIDTH + 3);
    localparam int CW    = ((PW > bbd_pkg::FW_W) ? PW : bbd_pkg::FW_W) + 1;
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int HW    = ((HB > bbd_pkg::FH_W) ? HB : bbd_pkg::FH_W) + 1;

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [PW-1:0]    pend_reg, pend_next, pend_inc;
    logic [CW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic             emit;
    logic             is_flush;

    function automatic logic [COL_W+ROW_W-1:0] advance(
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] row,
        input logic [CW-1:0]    w,
        input logic [HW-1:0]    h
    );
        logic [CW-1:0]    col_inc;
        logic [HW-1:0]    row_inc;
        logic [COL_W-1:0] col_n;
        logic [ROW_W-1:0] row_n;
        col_inc = CW'(col) + CW'(1);
        row_inc = HW'(row);
        col_n   = col_inc[COL_W-1:0];
        if (col_inc >= w)
        begin
            col_n   = '0;
            row_inc = HW'(row) + HW'(1);
        end
        row_n = row_inc[ROW_W-1:0];
        if (row_inc >= h)
        begin
            row_n = '0;
        end
        return {col_n, row_n};
    endfunction

    // Clamp the frame size to the supported range
    always_comb
    begin
        eff_w = CW'(frame_width);
        if (frame_width == '0)
        begin
            eff_w = CW'(1);
        end
        else if (CW'(frame_width) > CW'(MAX_WIDTH))
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        eff_h = HW'(frame_height);
        if (frame_height == '0)
        begin
            eff_h = HW'(1);
        end
        else if (HW'(frame_height) > HW'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
    end

    assign is_flush = (cmd == bbd_pkg::CMD_FLUSH);
    assign pend_inc = pend_reg + PW'(1);

    always_comb
    begin
        if (is_flush)
        begin
            emit = (pend_reg != '0) && (in_col_reg == '0) && (in_row_reg == '0);
        end
        else
        begin
            emit = CW'(pend_inc) > (eff_w + CW'(1));
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept)
        begin
            if (!is_flush)
            begin
                {in_col_next, in_row_next} = advance(in_col_reg, in_row_reg, eff_w, eff_h);
                pend_next = emit ? pend_reg : pend_inc;
            end
            else if (emit)
            begin
                pend_next = pend_reg - PW'(1);
            end
            if (emit)
            begin
                {out_col_next, out_row_next} = advance(out_col_reg, out_row_reg, eff_w, eff_h);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

    always_comb
    begin
        tag.raw    = !is_flush;
        tag.emit   = emit;
        tag.border = (out_col_reg == '0) || (out_row_reg == '0)
                     || ((CW'(out_col_reg) + CW'(1)) >= eff_w)
                     || ((HW'(out_row_reg) + HW'(1)) >= eff_h);
        tag.last   = ((CW'(out_col_reg) + CW'(1)) >= eff_w)
                     && ((HW'(out_row_reg) + HW'(1)) >= eff_h);
        tag.x_odd  = out_col_reg[0];
        tag.y_odd  = out_row_reg[0];
        tag.gray   = gray_mode;
    end

    assign rd_addr = in_col_reg;

endmodule

>>> rtl/bbd_interp.sv
module bbd_interp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          use_new,
    input  bbd_pkg::pix_t top,
    input  bbd_pkg::pix_t mid,
    input  bbd_pkg::pix_t px,
    input  bbd_pkg::tag_t tag,
    output bbd_pkg::pix_t red,
    output bbd_pkg::pix_t green,
    output bbd_pkg::pix_t blue,
    output bbd_pkg::pix_t gray
);

    bbd_pkg::pix_t win_reg [3][3];
    bbd_pkg::pix_t win_next [3][3];
    bbd_pkg::pix_t view [3][3];

    logic [9:0] diag, cross_sum, sum3;
    logic [8:0] horiz, vert;
    logic [bbd_pkg::DIV3_PROD_W-1:0] prod;
    bbd_pkg::pix_t r, g, b;

    // Shift left by one column, new column from the line stores and the pixel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top;
        win_next[1][2] = mid;
        win_next[2][2] = px;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                view[i][j] = use_new ? win_next[i][j] : win_reg[i][j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (shift)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        diag      = 10'(view[0][0]) + 10'(view[0][2]) + 10'(view[2][0]) + 10'(view[2][2]);
        cross_sum = 10'(view[0][1]) + 10'(view[1][0]) + 10'(view[1][2]) + 10'(view[2][1]);
        horiz = 9'(view[1][0]) + 9'(view[1][2]);
        vert  = 9'(view[0][1]) + 9'(view[2][1]);
        r = '0;
        g = '0;
        b = '0;
        if (!tag.border)
        begin
            case ({tag.y_odd, tag.x_odd})
                2'b00:
                begin
                    r = view[1][1];
                    g = cross_sum[9:2];
                    b = diag[9:2];
                end
                2'b01:
                begin
                    r = horiz[8:1];
                    g = view[1][1];
                    b = vert[8:1];
                end
                2'b10:
                begin
                    r = vert[8:1];
                    g = view[1][1];
                    b = horiz[8:1];
                end
                default:
                begin
                    r = diag[9:2];
                    g = cross_sum[9:2];
                    b = view[1][1];
                end
            endcase
        end
        sum3 = 10'(r) + 10'(g) + 10'(b);
        prod = bbd_pkg::DIV3_PROD_W'(sum3) * bbd_pkg::DIV3_PROD_W'(bbd_pkg::DIV3_MUL);
    end

    assign red   = tag.gray ? '0 : r;
    assign green = tag.gray ? '0 : g;
    assign blue  = tag.gray ? '0 : b;
    assign gray  = tag.gray ? prod[bbd_pkg::DIV3_SHIFT +: 8] : '0;

endmodule

>>> rtl/bayer_bilinear_demosaic.sv
// Channel  Handshake               Payload
// ------   ---------------------   ------------------------------------------
// in       in_valid / in_ready     cmd, raw_pixel
// out      out_valid / out_ready   red, green, blue, gray, last_of_frame
// cfg      psel/penable/pready     paddr, pwrite, pwdata, prdata (APB)
//
// One item per clock while out takes its results: the accepting edge reads
// both line stores, stage one shifts the window and computes the colors, the
// output register holds the result. out_valid rises when stage one loads its
// result into the output register. Reset clears counters, window and valid
// flags; line store contents stay undefined until written. A waiting result
// on out holds stage one only when its item also produces a result, and then
// drops in_ready.
module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  raw_pixel,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  gray,
    output logic        last_of_frame,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [bbd_pkg::FW_W-1:0] frame_width_reg;
    logic [bbd_pkg::FH_W-1:0] frame_height_reg;
    logic                     gray_mode_reg;
    logic                     cfg_write;
    logic [bbd_pkg::REG_IDX_W-1:0] reg_idx;

    // Pipeline
    logic            in_accept;
    logic            s1_fire;
    logic            out_free;
    logic            out_load;
    logic            s1_valid_reg, s1_valid_next;
    bbd_pkg::tag_t   s1_tag_reg;
    logic [AW-1:0]   s1_addr_reg;
    bbd_pkg::pix_t   s1_px_reg;
    bbd_pkg::tag_t   tag;
    logic [AW-1:0]   rd_addr;

    // Line stores and the bypass for back-to-back access to one column
    bbd_pkg::pix_t   upper_rdata, middle_rdata;
    bbd_pkg::pix_t   top_px, mid_px;
    logic            store_we;
    logic            fwd_hit_reg, fwd_hit_next;
    bbd_pkg::pix_t   fwd_top_reg, fwd_mid_reg;

    // Result
    logic            out_valid_reg, out_valid_next;
    bbd_pkg::pix_t   red_reg, green_reg, blue_reg, gray_reg;
    logic            last_reg;
    bbd_pkg::pix_t   red_c, green_c, blue_c, gray_c;

    // ------------------------------------------------------------------
    // APB register file: write in the access phase, never wait
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bbd_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bbd_pkg::FRAME_HEIGHT_RST;
            gray_mode_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                bbd_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[bbd_pkg::FW_W-1:0];
                bbd_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[bbd_pkg::FH_W-1:0];
                bbd_pkg::REG_GRAY_MODE:    gray_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bbd_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            bbd_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            bbd_pkg::REG_GRAY_MODE:    prdata = 32'(gray_mode_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: stage one advances unless it holds a result and the
    // output register is still occupied by an untaken transfer.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && (!s1_tag_reg.emit || out_free);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_accept = in_valid && in_ready;
    assign out_load  = s1_fire && s1_tag_reg.emit;

    // Stage zero: position counters, pending count and the emit decision
    bbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .cmd          (cmd),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .gray_mode    (gray_mode_reg),
        .rd_addr      (rd_addr),
        .tag          (tag)
    );

    // Both stores are read at the column of the incoming pixel and written
    // back from stage one when it advances: upper takes the old middle entry,
    // middle takes the new pixel.
    assign store_we = s1_fire && s1_tag_reg.raw;

    bbd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_addr_reg),
        .wdata (mid_px),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (upper_rdata)
    );

    bbd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_addr_reg),
        .wdata (s1_px_reg),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (middle_rdata)
    );

    // A one-pixel-wide frame reads the column that is being written in the
    // same cycle; take the write data instead of the stale read.
    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        if (in_accept)
        begin
            fwd_hit_next = store_we && (s1_addr_reg == rd_addr);
        end
        else if (s1_fire)
        begin
            fwd_hit_next = 1'b0;
        end
    end

    assign top_px = fwd_hit_reg ? fwd_top_reg : upper_rdata;
    assign mid_px = fwd_hit_reg ? fwd_mid_reg : middle_rdata;

    assign s1_valid_next = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    // Stage one payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tag_reg  <= tag;
            s1_addr_reg <= rd_addr;
            s1_px_reg   <= raw_pixel;
            fwd_top_reg <= mid_px;
            fwd_mid_reg <= s1_px_reg;
        end
    end

    // Stage one: window shift and interpolation
    bbd_interp u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (store_we),
        .use_new (s1_tag_reg.raw),
        .top     (top_px),
        .mid     (mid_px),
        .px      (s1_px_reg),
        .tag     (s1_tag_reg),
        .red     (red_c),
        .green   (green_c),
        .blue    (blue_c),
        .gray    (gray_c)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            gray_reg  <= gray_c;
            last_reg  <= s1_tag_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign gray          = gray_reg;
    assign last_of_frame = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken transfer");

    a_fwd_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("bypass flag set with stage one empty");

    a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_frame) |->
            (red == 8'd0 && green == 8'd0 && blue == 8'd0 && gray == 8'd0))
        else $error("last result of frame is not a border zero");

    a_gray_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (red != 8'd0 || green != 8'd0 || blue != 8'd0)) |-> (gray == 8'd0))
        else $error("gray and color both nonzero");

endmodule
